// ===== design/deadline_sorted_timer_queue_assert.svh =====
// Assertion macros for the checker file of the timer queue.
`ifndef DEADLINE_SORTED_TIMER_QUEUE_ASSERT_SVH
`define DEADLINE_SORTED_TIMER_QUEUE_ASSERT_SVH

// Concurrent check on clk_i, held off while rst_ni is low.
`define DSTQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent check that is also evaluated during reset.
`define DSTQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/dstq_pkg.sv =====
// Package of the timer queue: field widths, action codes, controller states, command and status structs.
`default_nettype none

package dstq_pkg;

  localparam int unsigned JOB_W = 16;  // job id field width
  localparam int unsigned DL_W  = 63;  // time and deadline field width

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POLL   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_PLACE,
    S_SCAN,
    S_EMIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture the input beat
    logic sum;        // register saturated deadline
    logic place;      // insert into the cell chain (or flag overflow)
    logic scan_step;  // move the head job to the release buffer
    logic out_load;   // load the output register
  } dstq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic head_ready;  // head entry exists and is due
    logic rel_any;     // release buffer not empty
    logic rel_last;    // exactly one job left in the release buffer
  } dstq_sts_t;

endpackage

`default_nettype wire

// ===== design/dstq_ctrl.sv =====
// Controller state machine of the timer queue: sequencing and output valid.
`default_nettype none

module dstq_ctrl
  import dstq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_action_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire dstq_sts_t sts_i,
  output dstq_cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   out_free;

  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (in_action_i == ACT_POLL) ? S_SCAN : S_SUM;
        end
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_PLACE;
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        state_d     = S_EMIT;
      end
      S_SCAN: begin
        if (sts_i.head_ready) begin
          cmd_o.scan_step = 1'b1;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          if (!sts_i.rel_any || sts_i.rel_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

`default_nettype wire

// ===== design/dstq_dpath.sv =====
// Datapath of the timer queue: sorted cell chain, release buffer, output register.
`default_nettype none

module dstq_dpath
  import dstq_pkg::*;
#(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned JOB_ID_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dstq_cmd_t        cmd_i,
  output dstq_sts_t             sts_o,
  input  wire logic [JOB_W-1:0] job_id_i,
  input  wire logic [DL_W-1:0]  delay_i,
  input  wire logic [DL_W-1:0]  now_i,
  output logic [JOB_W-1:0]      ready_job_o,
  output logic                  ready_valid_o,
  output logic                  last_o,
  output logic                  queue_empty_o,
  output logic [DL_W-1:0]       next_deadline_o,
  output logic                  overflow_o
);

  localparam int unsigned JW = (JOB_ID_BITS < JOB_W) ? JOB_ID_BITS : JOB_W;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // cell chain, entry 0 is the head
  logic [DL_W-1:0] dl_cell_q [DEPTH];
  logic [DL_W-1:0] dl_cell_d [DEPTH];
  logic [JW-1:0]   job_cell_q [DEPTH];
  logic [JW-1:0]   job_cell_d [DEPTH];
  logic [JW-1:0]   rel_q [DEPTH];
  logic [JW-1:0]   rel_d [DEPTH];
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   rel_cnt_q, rel_cnt_d;
  logic            ovf_q, ovf_d;

  logic [JW-1:0]   job_in_q;
  logic [DL_W-1:0] delay_q;
  logic [DL_W-1:0] now_q;
  logic [DL_W-1:0] dl_q;
  logic [DL_W:0]   dl_sum;
  logic [DL_W-1:0] dl_sat;
  logic [DEPTH-1:0] le;
  logic            full;

  logic [JOB_W-1:0] out_job_q;
  logic             out_rv_q;
  logic             out_last_q;
  logic             out_empty_q;
  logic [DL_W-1:0]  out_nd_q;
  logic             out_ovf_q;

  assign dl_sum = {1'b0, now_q} + {1'b0, delay_q};
  assign dl_sat = dl_sum[DL_W] ? '1 : dl_sum[DL_W-1:0];
  assign full   = (cnt_q == CW'(DEPTH));

  // entries due no later than the new deadline form a prefix
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le[i] = (cnt_q > CW'(i)) && (dl_cell_q[i] <= dl_q);
    end
  end

  assign sts_o.head_ready = (cnt_q != '0) && (dl_cell_q[0] <= now_q);
  assign sts_o.rel_any    = (rel_cnt_q != '0);
  assign sts_o.rel_last   = (rel_cnt_q == CW'(1));

  always_comb begin
    dl_cell_d  = dl_cell_q;
    job_cell_d = job_cell_q;
    rel_d      = rel_q;
    cnt_d      = cnt_q;
    rel_cnt_d  = rel_cnt_q;
    ovf_d      = ovf_q;
    if (cmd_i.load) begin
      ovf_d = 1'b0;
    end
    if (cmd_i.place) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CW'(1);
        if (!le[0]) begin
          dl_cell_d[0]  = dl_q;
          job_cell_d[0] = job_in_q;
        end
        for (int i = 1; i < DEPTH; i++) begin
          if (!le[i]) begin
            if (le[i-1]) begin
              dl_cell_d[i]  = dl_q;
              job_cell_d[i] = job_in_q;
            end else begin
              dl_cell_d[i]  = dl_cell_q[i-1];
              job_cell_d[i] = job_cell_q[i-1];
            end
          end
        end
      end
    end
    if (cmd_i.scan_step) begin
      cnt_d     = cnt_q - CW'(1);
      rel_cnt_d = rel_cnt_q + CW'(1);
      for (int i = 0; i < DEPTH - 1; i++) begin
        dl_cell_d[i]  = dl_cell_q[i+1];
        job_cell_d[i] = job_cell_q[i+1];
      end
      for (int i = 0; i < DEPTH; i++) begin
        if (rel_cnt_q == CW'(i)) begin
          rel_d[i] = job_cell_q[0];
        end
      end
    end
    if (cmd_i.out_load && (rel_cnt_q != '0)) begin
      rel_cnt_d = rel_cnt_q - CW'(1);
      for (int i = 0; i < DEPTH - 1; i++) begin
        rel_d[i] = rel_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      rel_cnt_q <= '0;
      ovf_q     <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      rel_cnt_q <= rel_cnt_d;
      ovf_q     <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dl_cell_q  <= dl_cell_d;
    job_cell_q <= job_cell_d;
    rel_q      <= rel_d;
    if (cmd_i.load) begin
      job_in_q <= job_id_i[JW-1:0];
      delay_q  <= delay_i;
      now_q    <= now_i;
    end
    if (cmd_i.sum) begin
      dl_q <= dl_sat;
    end
    if (cmd_i.out_load) begin
      out_job_q   <= (rel_cnt_q != '0) ? JOB_W'(rel_q[0]) : '0;
      out_rv_q    <= (rel_cnt_q != '0);
      out_last_q  <= (rel_cnt_q == '0) || (rel_cnt_q == CW'(1));
      out_empty_q <= (cnt_q == '0);
      out_nd_q    <= (cnt_q == '0) ? '0 : dl_cell_q[0];
      out_ovf_q   <= ovf_q;
    end
  end

  assign ready_job_o     = out_job_q;
  assign ready_valid_o   = out_rv_q;
  assign last_o          = out_last_q;
  assign queue_empty_o   = out_empty_q;
  assign next_deadline_o = out_nd_q;
  assign overflow_o      = out_ovf_q;

endmodule

`default_nettype wire

// ===== design/deadline_sorted_timer_queue.sv =====
// Top level of the deadline-sorted timer queue.
// Usage:
//  - Input stream (s_axis_*): one beat per request. tuser is the action
//    (0 insert, 1 poll). An insert stores job_id with deadline now + delay,
//    saturated at 2^63-1, behind every entry with an equal or earlier deadline.
//  - Output stream (m_axis_*): an insert gives one beat (overflow set when the
//    queue held DEPTH jobs and the job was dropped). A poll gives one beat per
//    released job (tuser = ready_valid high), tlast on the final one; a poll
//    that releases nothing gives a single status beat with tlast.
//  - Every beat of a request carries queue_empty and next_deadline as they
//    stand after the whole request.
//  - Sequence: an insert passes the SUM and PLACE states before its beat is
//    loaded in EMIT; a poll scans one head cell per cycle while the head is
//    due, then puts out one beat per cycle while the receiver takes them. The
//    next beat is accepted the cycle after the final result is loaded into the
//    output register.
//  - One request at a time: the cell chain shifts one position per cycle.
//  - Reset empties the queue; entry contents are not cleared.
//  - A stalled receiver holds the output register; a poll with several
//    releases waits in the controller until each beat is taken.
`default_nettype none

module deadline_sorted_timer_queue
  import dstq_pkg::*;
#(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned JOB_ID_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [143:0] s_axis_tdata,   // job_id[15:0], delay_ns[78:16], now_ns[141:79]
  input  wire logic         s_axis_tuser,   // action
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [87:0]       m_axis_tdata,   // ready_job[15:0], queue_empty[16],
                                            // next_deadline[79:17], overflow[80]
  output logic              m_axis_tuser,   // ready_valid
  output logic              m_axis_tlast    // last
);

  dstq_cmd_t        cmd;
  dstq_sts_t        sts;
  logic [JOB_W-1:0] ready_job;
  logic             ready_valid;
  logic             last;
  logic             queue_empty;
  logic [DL_W-1:0]  next_deadline;
  logic             overflow;

  dstq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dstq_dpath #(
    .DEPTH       (DEPTH),
    .JOB_ID_BITS (JOB_ID_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .job_id_i        (s_axis_tdata[15:0]),
    .delay_i         (s_axis_tdata[78:16]),
    .now_i           (s_axis_tdata[141:79]),
    .ready_job_o     (ready_job),
    .ready_valid_o   (ready_valid),
    .last_o          (last),
    .queue_empty_o   (queue_empty),
    .next_deadline_o (next_deadline),
    .overflow_o      (overflow)
  );

  assign m_axis_tdata = {7'd0, overflow, next_deadline, queue_empty, ready_job};
  assign m_axis_tuser = ready_valid;
  assign m_axis_tlast = last;

endmodule

`default_nettype wire

// ===== design/dstq_checker.sv =====
// Port-level checker of the timer queue and its bind to the top level.
`default_nettype none

`include "deadline_sorted_timer_queue_assert.svh"

module dstq_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic [143:0] s_axis_tdata,
  input wire logic         s_axis_tuser,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [87:0]  m_axis_tdata,
  input wire logic         m_axis_tuser,
  input wire logic         m_axis_tlast
);

  // a beat without a released job ends its request
  `DSTQ_ASSERT(a_status_is_last, m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast, "status beat without tlast")

  // an empty queue reports a zero head deadline
  `DSTQ_ASSERT(a_empty_zero_dl, m_axis_tvalid && m_axis_tdata[16] |-> (m_axis_tdata[79:17] == '0), "empty queue with nonzero deadline")

  // overflow only on the single result of an insert
  `DSTQ_ASSERT(a_ovf_single, m_axis_tvalid && m_axis_tdata[80] |-> !m_axis_tuser && m_axis_tlast && !m_axis_tdata[16], "overflow on a release beat")

  // a stalled output beat holds
  `DSTQ_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")

endmodule

bind deadline_sorted_timer_queue dstq_checker u_dstq_checker (.*);

`default_nettype wire
